### design/ptrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ptrs_pkg;

  // field widths
  localparam int TYPE_W = 6;
  localparam int ACT_W  = 2;
  localparam int CNT_W  = 32;
  localparam int RATE_W = 48;
  localparam int KEEP_W = 16;

  // defaults
  localparam int ENTRIES_DEF = 16;
  localparam logic [KEEP_W-1:0] KEEP_RESET = 16'd58982;

  // action codes
  localparam logic [ACT_W-1:0] ACT_COUNT  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PERIOD = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RESET  = 2'd2;

  // result status codes
  localparam logic STATUS_REPORT   = 1'b0;
  localparam logic STATUS_BAD_TYPE = 1'b1;

  // one statistics entry as stored in memory
  typedef struct packed {
    logic [CNT_W-1:0]  sent_cnt;
    logic [CNT_W-1:0]  recv_cnt;
    logic [RATE_W-1:0] sent_rate;
    logic [RATE_W-1:0] recv_rate;
  } entry_t;

  // memory port controls
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear;
  } mem_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COUNT,
    S_ERROR,
    S_READ,
    S_MUL,
    S_SUM
  } state_t;

endpackage
`default_nettype wire

### design/ptrs_store.sv
`timescale 1ns / 1ps
`default_nettype none
module ptrs_store #(
  parameter int ENTRIES = ptrs_pkg::ENTRIES_DEF,
  parameter int AW      = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ptrs_pkg::mem_ctl_t ctl,
  input  wire logic [AW-1:0]     rd_addr,
  output ptrs_pkg::entry_t       rd_data,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire ptrs_pkg::entry_t  wr_data
);
  import ptrs_pkg::*;

  entry_t             mem [ENTRIES];
  entry_t             mem_q;
  logic [ENTRIES-1:0] valid;
  logic               hit;

  // statistics memory, one read and one write port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      mem_q <= mem[rd_addr];
      hit   <= valid[rd_addr];
    end
  end

  // per-entry valid bits; an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      valid <= '0;
    end else if (ctl.wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = hit ? mem_q : '0;

endmodule
`default_nettype wire

### design/ptrs_smooth.sv
`timescale 1ns / 1ps
`default_nettype none
module ptrs_smooth (
  input  wire logic                        clk,
  input  wire logic                        load,
  input  wire logic [ptrs_pkg::KEEP_W-1:0] keep,
  input  wire logic [ptrs_pkg::RATE_W-1:0] rate,
  input  wire logic [ptrs_pkg::CNT_W-1:0]  count,
  output logic      [ptrs_pkg::RATE_W-1:0] result
);
  import ptrs_pkg::*;

  localparam int HALF = RATE_W / 2;
  localparam int FULL = KEEP_W + RATE_W;

  logic [KEEP_W:0]        fresh;
  logic [KEEP_W+HALF-1:0] prod_hi;
  logic [KEEP_W+HALF-1:0] prod_lo;
  logic [KEEP_W+CNT_W:0]  prod_new;
  logic [FULL-1:0]        held_full;

  // weight of the new count: 1.0 - keep
  assign fresh = {1'b1, {KEEP_W{1'b0}}} - {1'b0, keep};

  // stage 1: partial products of keep*rate and the count term
  always_ff @(posedge clk) begin
    if (load) begin
      prod_hi  <= keep * rate[RATE_W-1:HALF];
      prod_lo  <= keep * rate[HALF-1:0];
      prod_new <= fresh * count;
    end
  end

  // stage 2: recombine, drop the Q0.16 fraction, add count term mod 2^48
  assign held_full = {prod_hi, {HALF{1'b0}}} + FULL'(prod_lo);
  assign result    = held_full[FULL-1:KEEP_W] + prod_new[RATE_W-1:0];

endmodule
`default_nettype wire

### design/per_type_event_rate_smoother_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Handshake                 Payload
// in       sink       in_valid / in_ready       action, msg_type, direction_out
// out      source     out_valid / out_ready     status, entry_index, sent_rate,
//                                               recv_rate, last
// cfg      sink       cfg_wr_en                 cfg_wr_data (keep fraction)
//
// Count beat: memory read, then saturating write back.
// Period beat: accept, then read, multiply, sum/write per entry, with each
// sum/write held while out_ready low holds the output register.
// Reset beat: per-entry valid bits clear at once, no clearing pass.
// Bad-type beat: accept, then result load, which waits for a free
// output register.
// rst is synchronous; out_ready low stalls only period and error results.
module per_type_event_rate_smoother_core #(
  parameter int ENTRIES = ptrs_pkg::ENTRIES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic [ptrs_pkg::KEEP_W-1:0] cfg_wr_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [ptrs_pkg::ACT_W-1:0]  action,
  input  wire logic [ptrs_pkg::TYPE_W-1:0] msg_type,
  input  wire logic                        direction_out,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             status,
  output logic      [ptrs_pkg::TYPE_W-1:0] entry_index,
  output logic      [ptrs_pkg::RATE_W-1:0] sent_rate,
  output logic      [ptrs_pkg::RATE_W-1:0] recv_rate,
  output logic                             last
);
  import ptrs_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [AW-1:0] IDX_LAST = AW'(ENTRIES - 1);

  state_t            state, state_next;
  logic [KEEP_W-1:0] keep;
  logic [TYPE_W-1:0] item_type;
  logic              item_dir;
  logic [AW-1:0]     idx;
  logic              accept;
  logic              in_range;
  logic              out_free;
  logic              out_load;
  logic              out_status_next;
  logic [TYPE_W-1:0] out_index_next;
  logic              out_last_next;
  logic              mul_load;
  mem_ctl_t          ctl;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  entry_t            rd_data;
  entry_t            wr_data;
  logic [RATE_W-1:0] sent_new;
  logic [RATE_W-1:0] recv_new;

  assign accept   = in_valid && in_ready;
  assign in_range = {1'b0, msg_type} < (TYPE_W + 1)'(ENTRIES);
  assign out_free = !out_valid || out_ready;

  // keep fraction register
  always_ff @(posedge clk) begin
    if (rst) begin
      keep <= KEEP_RESET;
    end else if (cfg_wr_en) begin
      keep <= cfg_wr_data;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority if (action == ACT_COUNT) begin
            state_next = in_range ? S_COUNT : S_ERROR;
          end else if (action == ACT_PERIOD) begin
            state_next = S_READ;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_COUNT: state_next = S_IDLE;
      S_ERROR: state_next = out_free ? S_IDLE : S_ERROR;
      S_READ:  state_next = S_MUL;
      S_MUL:   state_next = S_SUM;
      S_SUM: begin
        if (out_free) begin
          state_next = (idx == IDX_LAST) ? S_IDLE : S_READ;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready        = 1'b0;
    ctl             = '0;
    rd_addr         = idx;
    wr_addr         = idx;
    wr_data         = rd_data;
    out_load        = 1'b0;
    out_status_next = STATUS_REPORT;
    out_index_next  = TYPE_W'(idx);
    out_last_next   = 1'b0;
    mul_load        = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        rd_addr   = msg_type[AW-1:0];
        ctl.rd_en = accept && (action == ACT_COUNT) && in_range;
        ctl.clear = accept && (action == ACT_RESET);
      end
      S_COUNT: begin
        ctl.wr_en = 1'b1;
        wr_addr   = item_type[AW-1:0];
        if (item_dir) begin
          if (rd_data.sent_cnt != '1) begin
            wr_data.sent_cnt = rd_data.sent_cnt + CNT_W'(1);
          end
        end else begin
          if (rd_data.recv_cnt != '1) begin
            wr_data.recv_cnt = rd_data.recv_cnt + CNT_W'(1);
          end
        end
      end
      S_ERROR: begin
        out_load        = out_free;
        out_status_next = STATUS_BAD_TYPE;
        out_index_next  = item_type;
        out_last_next   = 1'b1;
      end
      S_READ: begin
        ctl.rd_en = 1'b1;
      end
      S_MUL: begin
        mul_load = 1'b1;
      end
      S_SUM: begin
        ctl.wr_en         = out_free;
        out_load          = out_free;
        wr_data.sent_cnt  = '0;
        wr_data.recv_cnt  = '0;
        wr_data.sent_rate = sent_new;
        wr_data.recv_rate = recv_new;
        out_last_next     = (idx == IDX_LAST);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // item capture and sweep index
  always_ff @(posedge clk) begin
    if (accept) begin
      item_type <= msg_type;
      item_dir  <= direction_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (accept) begin
      idx <= '0;
    end else if (state == S_SUM && out_free) begin
      idx <= idx + AW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status      <= out_status_next;
      entry_index <= out_index_next;
      last        <= out_last_next;
      sent_rate   <= (state == S_SUM) ? sent_new : '0;
      recv_rate   <= (state == S_SUM) ? recv_new : '0;
    end
  end

  ptrs_store #(
    .ENTRIES (ENTRIES),
    .AW      (AW)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  ptrs_smooth u_smooth_sent (
    .clk    (clk),
    .load   (mul_load),
    .keep   (keep),
    .rate   (rd_data.sent_rate),
    .count  (rd_data.sent_cnt),
    .result (sent_new)
  );

  ptrs_smooth u_smooth_recv (
    .clk    (clk),
    .load   (mul_load),
    .keep   (keep),
    .rate   (rd_data.recv_rate),
    .count  (rd_data.recv_cnt),
    .result (recv_new)
  );

endmodule
`default_nettype wire

### design/ptrs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module ptrs_checker #(
  parameter int ENTRIES = ptrs_pkg::ENTRIES_DEF
) (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic [ptrs_pkg::ACT_W-1:0]  action,
  input wire logic [ptrs_pkg::TYPE_W-1:0] msg_type,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic                        status,
  input wire logic [ptrs_pkg::TYPE_W-1:0] entry_index,
  input wire logic [ptrs_pkg::RATE_W-1:0] sent_rate,
  input wire logic [ptrs_pkg::RATE_W-1:0] recv_rate,
  input wire logic                        last
);
  import ptrs_pkg::*;

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sent_rate) && $stable(recv_rate)
      && $stable(entry_index) && $stable(last) && $stable(status))
    else $error("stalled result beat changed");

  // bad-type results are single, zero-rate beats
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_BAD_TYPE) |->
      last && (sent_rate == '0) && (recv_rate == '0))
    else $error("bad-type result malformed");

  // report beats stay in range and mark the final entry
  a_report_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_REPORT) |->
      ({1'b0, entry_index} < (TYPE_W + 1)'(ENTRIES))
      && (last == (entry_index == TYPE_W'(ENTRIES - 1))))
    else $error("report index or last mark wrong");

  // a count beat holds the input for its write-back cycle
  a_count_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (action == ACT_COUNT)
      && ({1'b0, msg_type} < (TYPE_W + 1)'(ENTRIES))
      |=> !in_ready)
    else $error("input taken during count write-back");

  // a period beat produces no result in the next cycle beyond a held one
  a_period_start: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (action == ACT_PERIOD) && !out_valid |=> !out_valid)
    else $error("result appeared before sweep read");

endmodule

bind per_type_event_rate_smoother_core ptrs_checker #(.ENTRIES(ENTRIES)) u_ptrs_checker (.*);
`default_nettype wire

### bench/per_type_event_rate_smoother_core_tb.sv
`timescale 1ns / 1ps
module per_type_event_rate_smoother_core_tb;
  import ptrs_pkg::*;

  localparam int ENTRIES = ENTRIES_DEF;
  // spare action code, ignored by the block
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
  // a period walks read, multiply and sum per entry; margin for the last count write back
  localparam int SETTLE_CYCLES = 3 * ENTRIES + 12;
  localparam int BEATS_PER_PHASE = 57;
  localparam int N_PHASES = 5;
  localparam int N_DIRECTED = 24;
  localparam int MAX_PRINTED = 40;
  localparam longint TIMEOUT_NS = 64'd5_000_000;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [TYPE_W-1:0] typ;
    logic              sent_dir;
  } beat_t;

  // typed rows carry a hand-written expectation: bad type, or all rates zero
  typedef struct packed {
    beat_t beat;
    bit    typed;
  } dir_row_t;

  typedef struct packed {
    logic              status;
    logic [TYPE_W-1:0] idx;
    logic [RATE_W-1:0] sent;
    logic [RATE_W-1:0] recv;
    logic              last;
  } report_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_wr_en;
  logic [KEEP_W-1:0]   cfg_wr_data;
  logic                in_valid;
  logic                in_ready;
  logic [ACT_W-1:0]    action;
  logic [TYPE_W-1:0]   msg_type;
  logic                direction_out;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                status;
  logic [TYPE_W-1:0]   entry_index;
  logic [RATE_W-1:0]   sent_rate;
  logic [RATE_W-1:0]   recv_rate;
  logic                last;

  // predictor state
  logic [CNT_W-1:0]  sent_cnt [ENTRIES];
  logic [CNT_W-1:0]  recv_cnt [ENTRIES];
  logic [RATE_W-1:0] sent_avg [ENTRIES];
  logic [RATE_W-1:0] recv_avg [ENTRIES];
  logic [KEEP_W-1:0] keep_now;

  report_t predicted_reports[$];
  report_t expected_reports[$];

  bit calm = 1'b0;
  int mismatches = 0;
  int beats_sent = 0;
  int reports_checked = 0;
  int periods_sent = 0;
  int bad_types_sent = 0;
  int keep_settings = 1;

  dir_row_t directed_rows [N_DIRECTED] = '{
    '{'{ACT_PERIOD, 6'd0,  1'b0}, 1'b1},  // fresh after reset: all zero
    '{'{ACT_COUNT,  6'd0,  1'b1}, 1'b0},
    '{'{ACT_COUNT,  6'd0,  1'b0}, 1'b0},
    '{'{ACT_COUNT,  6'd15, 1'b1}, 1'b0},
    '{'{ACT_COUNT,  6'd15, 1'b0}, 1'b0},
    '{'{ACT_COUNT,  6'd16, 1'b1}, 1'b1},  // first type out of range
    '{'{ACT_COUNT,  6'd63, 1'b0}, 1'b1},
    '{'{ACT_COUNT,  6'd42, 1'b1}, 1'b1},
    '{'{ACT_COUNT,  6'd21, 1'b0}, 1'b1},
    '{'{ACT_SPARE,  6'd5,  1'b1}, 1'b0},  // ignored
    '{'{ACT_SPARE,  6'd26, 1'b0}, 1'b0},
    '{'{ACT_PERIOD, 6'd63, 1'b1}, 1'b0},
    '{'{ACT_COUNT,  6'd7,  1'b1}, 1'b0},
    '{'{ACT_COUNT,  6'd7,  1'b1}, 1'b0},
    '{'{ACT_COUNT,  6'd7,  1'b0}, 1'b0},
    '{'{ACT_PERIOD, 6'd0,  1'b0}, 1'b0},
    '{'{ACT_PERIOD, 6'd0,  1'b0}, 1'b0},  // decay with no events
    '{'{ACT_RESET,  6'd9,  1'b1}, 1'b0},
    '{'{ACT_PERIOD, 6'd0,  1'b0}, 1'b1},  // rates wiped by reset item
    '{'{ACT_COUNT,  6'd3,  1'b0}, 1'b0},
    '{'{ACT_RESET,  6'd0,  1'b0}, 1'b0},
    '{'{ACT_PERIOD, 6'd12, 1'b1}, 1'b1},  // pending count wiped too
    '{'{ACT_COUNT,  6'd10, 1'b1}, 1'b0},
    '{'{ACT_PERIOD, 6'd0,  1'b0}, 1'b0}
  };

  per_type_event_rate_smoother_core #(
    .ENTRIES(ENTRIES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .msg_type(msg_type),
    .direction_out(direction_out),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .entry_index(entry_index),
    .sent_rate(sent_rate),
    .recv_rate(recv_rate),
    .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // keep*rate + (1-keep)*count in Q32.16, truncated
  function automatic logic [RATE_W-1:0] smoothed(input logic [RATE_W-1:0] avg,
                                                 input logic [CNT_W-1:0] cnt);
    logic [63:0] keep64;
    logic [63:0] fresh64;
    logic [63:0] avg64;
    logic [63:0] cnt64;
    logic [63:0] mix;
    keep64 = {48'd0, keep_now};
    fresh64 = 64'd65536 - keep64;
    avg64 = {16'd0, avg};
    cnt64 = {32'd0, cnt};
    mix = ((keep64 * avg64) >> 16) + fresh64 * cnt64;
    return mix[RATE_W-1:0];
  endfunction

  task automatic clear_stats(input bit rates_too);
    for (int i = 0; i < ENTRIES; i++) begin
      sent_cnt[i] = '0;
      recv_cnt[i] = '0;
      if (rates_too) begin
        sent_avg[i] = '0;
        recv_avg[i] = '0;
      end
    end
  endtask

  // updates predictor state and leaves the reports of one beat in predicted_reports
  task automatic predict_rates(input beat_t b);
    logic [TYPE_W-1:0] idx_v;
    predicted_reports = {};
    case (b.act)
      ACT_COUNT: begin
        if (b.typ >= ENTRIES) begin
          predicted_reports.push_back('{STATUS_BAD_TYPE, b.typ, '0, '0, 1'b1});
        end else if (b.sent_dir) begin
          if (sent_cnt[b.typ] != '1) sent_cnt[b.typ] = sent_cnt[b.typ] + 1'b1;
        end else begin
          if (recv_cnt[b.typ] != '1) recv_cnt[b.typ] = recv_cnt[b.typ] + 1'b1;
        end
      end
      ACT_PERIOD: begin
        for (int i = 0; i < ENTRIES; i++) begin
          idx_v = i[TYPE_W-1:0];
          sent_avg[i] = smoothed(sent_avg[i], sent_cnt[i]);
          recv_avg[i] = smoothed(recv_avg[i], recv_cnt[i]);
          predicted_reports.push_back('{STATUS_REPORT, idx_v, sent_avg[i], recv_avg[i],
                                        i == ENTRIES - 1});
        end
        clear_stats(1'b0);
      end
      ACT_RESET: clear_stats(1'b1);
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what);
    // cap the log; every mismatch is still counted
    if (mismatches < MAX_PRINTED) $display("MISMATCH @%0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [RATE_W-1:0] got,
                             input logic [RATE_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("report %0d %s: got 0x%0h, expected 0x%0h",
                                reports_checked, name, got, want));
  endtask

  // drive one input beat, hold it until accepted, then queue its reports
  task automatic send_beat(input beat_t b, input bit typed);
    logic [TYPE_W-1:0] idx_v;
    if (!calm) begin
      while ($urandom_range(99) < 35) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    action <= b.act;
    msg_type <= b.typ;
    direction_out <= b.sent_dir;
    do @(posedge clk); while (!in_ready);
    predict_rates(b);
    beats_sent++;
    if (b.act == ACT_PERIOD) periods_sent++;
    if (b.act == ACT_COUNT && b.typ >= ENTRIES) bad_types_sent++;
    if (!typed) begin
      foreach (predicted_reports[k]) expected_reports.push_back(predicted_reports[k]);
    end else if (b.act == ACT_PERIOD) begin
      for (int i = 0; i < ENTRIES; i++) begin
        idx_v = i[TYPE_W-1:0];
        expected_reports.push_back('{STATUS_REPORT, idx_v, '0, '0, i == ENTRIES - 1});
      end
    end else begin
      expected_reports.push_back('{STATUS_BAD_TYPE, b.typ, '0, '0, 1'b1});
    end
  endtask

  // block idle: no beat offered, all reports in, last count written back
  task automatic settle_block();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_keep(input logic [KEEP_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    keep_now = value;
    keep_settings++;
  endtask

  // mostly valid counts, hot on a few types, with periods, resets, errors and noise
  function automatic beat_t random_beat();
    beat_t b;
    int pick;
    pick = $urandom_range(99);
    b.typ = TYPE_W'($urandom_range(63));
    b.sent_dir = 1'($urandom_range(1));
    if (pick < 72) begin
      b.act = ACT_COUNT;
      b.typ = TYPE_W'($urandom_range(1) ? $urandom_range(3) : $urandom_range(ENTRIES - 1));
    end else if (pick < 80) begin
      b.act = ACT_COUNT;
      b.typ = TYPE_W'($urandom_range(63, ENTRIES));
    end else if (pick < 91) begin
      b.act = ACT_PERIOD;
    end else if (pick < 95) begin
      b.act = ACT_RESET;
    end else begin
      b.act = ACT_SPARE;
    end
    return b;
  endfunction

  // result sink stalls at random except in the calm phase
  always @(posedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 35);
    end
  end

  // compare each accepted result beat against the oldest expectation
  always @(posedge clk) begin : watch_reports
    report_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        report_mismatch($sformatf("unexpected report beat, entry %0d status %0d",
                                  entry_index, status));
      end else begin
        want = expected_reports.pop_front();
        check_field("status", RATE_W'(status), RATE_W'(want.status));
        check_field("entry_index", RATE_W'(entry_index), RATE_W'(want.idx));
        check_field("sent_rate", sent_rate, want.sent);
        check_field("recv_rate", recv_rate, want.recv);
        check_field("last", RATE_W'(last), RATE_W'(want.last));
        reports_checked++;
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    action = ACT_COUNT;
    msg_type = '0;
    direction_out = 1'b0;
    keep_now = KEEP_RESET;
    clear_stats(1'b1);
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table, keep at its reset value
    foreach (directed_rows[n]) send_beat(directed_rows[n].beat, directed_rows[n].typed);
    settle_block();

    // random phases, each under its own keep fraction
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: set_keep('0);
        1: set_keep('1);
        2: set_keep(KEEP_W'($urandom_range(65535)));
        3: set_keep(KEEP_RESET);
        default: set_keep(KEEP_W'($urandom_range(65534, 1)));
      endcase
      calm <= (ph == N_PHASES - 1);
      repeat (BEATS_PER_PHASE) send_beat(random_beat(), 1'b0);
      settle_block();
    end

    if (expected_reports.size() != 0)
      report_mismatch($sformatf("%0d reports never arrived", expected_reports.size()));
    $display("Sent %0d input beats (%0d period ends, %0d bad types) under %0d keep settings",
             beats_sent, periods_sent, bad_types_sent, keep_settings);
    $display("Checked %0d report beats, %0d mismatches", reports_checked, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timeout: %0d reports still outstanding", expected_reports.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### sim.f
design/ptrs_pkg.sv
design/ptrs_store.sv
design/ptrs_smooth.sv
design/per_type_event_rate_smoother_core.sv
design/ptrs_checker.sv
bench/per_type_event_rate_smoother_core_tb.sv
